### src/fsna_pkg.sv
// ----------------------------------------------------------------------------
// fsna_pkg
// Shared widths, codes and reset values of the fixed-size node allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsna_pkg;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int NSIZE_W  = 16;
    localparam int NCOUNT_W = 13;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Stream packing
    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 64;
    localparam int OUT_ADDR_LSB = 0;
    localparam int OUT_STAT_LSB = ADDR_W;
    localparam int OUT_USED_LSB = ADDR_W + STAT_W;

    // Build defaults
    localparam int DEF_MAX_SLOTS = 4096;
    localparam int DEF_ADDR_BITS = 48;

    // Register reset values
    localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
    localparam logic [NSIZE_W-1:0]  NSIZE_RST  = 16'd64;
    localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 13'd4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NCOUNT = 2'd2;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

`default_nettype wire

### src/fixed_size_node_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_size_node_allocator_top
// Slot allocator with a LIFO of freed slots, a fresh-slot counter and an
// in-use map, sharing one multiplier and one subtract/compare divider step.
// ----------------------------------------------------------------------------
// Steps: allocate runs MUL, ADD, OUT from a fresh slot, POP, MUL, ADD, OUT from the freed
//   LIFO, OUT alone when out of slots; free runs FCHK, FCMP, DIV, MAPRD, MAPCHK, OUT, or
//   FCHK, FCMP, OUT when out of range. Throughput: one request at a time; the next is
//   taken the cycle after the result is handed over; the restoring DIV yields one quotient bit a cycle.
// Reset: synchronous, active low; no clearing pass, the in-use map is trusted
//   only below the fresh-slot counter.
`default_nettype none

module fixed_size_node_allocator_top #(
    parameter int MAX_SLOTS = fsna_pkg::DEF_MAX_SLOTS,
    parameter int ADDR_BITS = fsna_pkg::DEF_ADDR_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [fsna_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fsna_pkg::ADDR_W-1:0]       i_cfg_data,
    // Request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [fsna_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [47:0] free_address
    input  wire logic [fsna_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // [0] op
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [fsna_pkg::OUT_TDATA_W-1:0]       m_axis_tdata   // [47:0] slot_address,
                                                                  // [49:48] status,
                                                                  // [62:50] used_slots
);

    localparam int ADDR_W  = fsna_pkg::ADDR_W;
    localparam int NSIZE_W = fsna_pkg::NSIZE_W;
    localparam int NCNT_W  = fsna_pkg::NCOUNT_W;
    localparam int STAT_W  = fsna_pkg::STAT_W;
    // Slot index, counters that can hold MAX_SLOTS itself, product of a count and the node size
    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int LIM_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (LIM_W > NCNT_W) ? LIM_W : NCNT_W;
    localparam int PROD_W  = LIM_W + NSIZE_W;
    localparam int CNT_W   = $clog2(IDX_W + 1);
    // Slot addresses wrap at the narrower of ADDR_BITS and the field width
    localparam int AM_W    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AM_W);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_POP    = 10'b00_0000_0010,
        S_MUL    = 10'b00_0000_0100,
        S_ADD    = 10'b00_0000_1000,
        S_FCHK   = 10'b00_0001_0000,
        S_FCMP   = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_MAPRD  = 10'b00_1000_0000,
        S_MAPCHK = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    // Configuration registers
    logic [ADDR_W-1:0]  r_base;
    logic [NSIZE_W-1:0] r_nsize;
    logic [NCNT_W-1:0]  r_ncount;

    // Control state
    t_state             r_state,  n_state;
    logic [LIM_W-1:0]   r_depth,  n_depth;   // entries on the freed LIFO
    logic [LIM_W-1:0]   r_fresh,  n_fresh;   // lowest slot never handed out
    logic [LIM_W-1:0]   r_used,   n_used;    // slots in use

    // Datapath
    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [PROD_W-1:0]  r_prod,   n_prod;
    logic [ADDR_W-1:0]  r_offset, n_offset;
    logic               r_below,  n_below;
    logic [PROD_W-1:0]  r_rem,    n_rem;
    logic [PROD_W-1:0]  r_dvs,    n_dvs;
    logic [IDX_W-1:0]   r_quo,    n_quo;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;
    logic [ADDR_W-1:0]  r_oaddr,  n_oaddr;
    logic [STAT_W-1:0]  r_ostat,  n_ostat;

    // Memories
    logic               m_map   [MAX_SLOTS];
    logic [IDX_W-1:0]   m_stack [MAX_SLOTS];
    logic               r_map_rd;
    logic [IDX_W-1:0]   r_stk_rd;

    logic               w_map_we;
    logic [IDX_W-1:0]   w_map_wa;
    logic               w_map_wd;
    logic               w_stk_we;

    logic [LIM_W-1:0]   w_limit;
    logic [LIM_W-1:0]   w_mul_a;
    logic [PROD_W-1:0]  w_prod;
    logic [LIM_W-1:0]   w_dec;
    logic               w_ge;
    logic               w_accept;
    logic               w_hit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, NCNT_W'(r_used), r_ostat, r_oaddr};

    // Usable slots: min(node_count, MAX_SLOTS)
    always_comb begin
        if (CMP_W'(r_ncount) < CMP_W'(MAX_SLOTS)) begin
            w_limit = LIM_W'(r_ncount);
        end else begin
            w_limit = LIM_W'(MAX_SLOTS);
        end
    end

    // Shared multiplier: slot limit for the free range check, slot index for
    // the allocate address.
    assign w_mul_a = (r_state == S_FCHK) ? w_limit : LIM_W'(r_idx);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(r_nsize);

    assign w_dec = r_depth - LIM_W'(1);
    assign w_ge  = (r_rem >= r_dvs);
    // The map is only trusted below the fresh counter; above it nothing was
    // ever handed out.
    assign w_hit = r_map_rd && (LIM_W'(r_quo) < r_fresh);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= fsna_pkg::BASE_RST;
            r_nsize  <= fsna_pkg::NSIZE_RST;
            r_ncount <= fsna_pkg::NCOUNT_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == fsna_pkg::CFG_BASE) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_index == fsna_pkg::CFG_NSIZE) begin
                r_nsize <= i_cfg_data[NSIZE_W-1:0];
            end
            if (i_cfg_index == fsna_pkg::CFG_NCOUNT) begin
                r_ncount <= i_cfg_data[NCNT_W-1:0];
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_fresh  = r_fresh;
        n_used   = r_used;
        n_idx    = r_idx;
        n_prod   = r_prod;
        n_offset = r_offset;
        n_below  = r_below;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_oaddr  = r_oaddr;
        n_ostat  = r_ostat;
        w_map_we = 1'b0;
        w_map_wa = r_idx;
        w_map_wd = 1'b1;
        w_stk_we = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_offset = s_axis_tdata[ADDR_W-1:0] - r_base;
                    n_below  = (s_axis_tdata[ADDR_W-1:0] < r_base);
                    n_oaddr  = '0;
                    if (s_axis_tuser[0] == fsna_pkg::OP_FREE) begin
                        n_state = S_FCHK;
                    end else if (r_depth != '0) begin
                        // LIFO top was read at depth-1 this edge
                        n_depth = w_dec;
                        n_state = S_POP;
                    end else if (r_fresh < w_limit) begin
                        n_idx   = r_fresh[IDX_W-1:0];
                        n_fresh = r_fresh + LIM_W'(1);
                        n_state = S_MUL;
                    end else begin
                        n_ostat = fsna_pkg::ST_NO_SLOT;
                        n_state = S_OUT;
                    end
                end
            end
            S_POP: begin
                n_idx   = r_stk_rd;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = w_prod;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_oaddr  = (r_base + ADDR_W'(r_prod)) & ADDR_MASK;
                n_ostat  = fsna_pkg::ST_OK;
                n_used   = r_used + LIM_W'(1);
                w_map_we = 1'b1;
                w_map_wa = r_idx;
                w_map_wd = 1'b1;
                n_state  = S_OUT;
            end
            S_FCHK: begin
                n_prod  = w_prod;
                n_state = S_FCMP;
            end
            S_FCMP: begin
                // offset >= limit * size covers a zero size as well
                if (r_below || (r_offset >= ADDR_W'(r_prod))) begin
                    n_ostat = fsna_pkg::ST_BAD_FREE;
                    n_state = S_OUT;
                end else begin
                    n_rem   = r_offset[PROD_W-1:0];
                    n_dvs   = PROD_W'(r_nsize) << (IDX_W - 1);
                    n_quo   = '0;
                    n_cnt   = CNT_W'(IDX_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring step: quotient bit from MSB down
                if (w_ge) begin
                    n_rem = r_rem - r_dvs;
                end
                n_quo = IDX_W'({r_quo, w_ge});
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_MAPRD;
                end
            end
            S_MAPRD: begin
                n_state = S_MAPCHK;
            end
            S_MAPCHK: begin
                if (w_hit) begin
                    w_map_we = 1'b1;
                    w_map_wa = r_quo;
                    w_map_wd = 1'b0;
                    if (r_used != '0) begin
                        n_used = r_used - LIM_W'(1);
                    end
                    if (r_depth != LIM_W'(MAX_SLOTS)) begin
                        w_stk_we = 1'b1;
                        n_depth  = r_depth + LIM_W'(1);
                    end
                    n_ostat = fsna_pkg::ST_OK;
                end else begin
                    n_ostat = fsna_pkg::ST_BAD_FREE;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_fresh <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_prod   <= n_prod;
        r_offset <= n_offset;
        r_below  <= n_below;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_oaddr  <= n_oaddr;
        r_ostat  <= n_ostat;
    end

    // In-use map: one write port, one registered read at the quotient
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            m_map[w_map_wa] <= w_map_wd;
        end
        r_map_rd <= m_map[r_quo];
    end

    // Freed LIFO: push at depth, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            m_stack[r_depth[IDX_W-1:0]] <= r_quo;
        end
        r_stk_rd <= m_stack[w_dec[IDX_W-1:0]];
    end

endmodule

`default_nettype wire

### src/fsna_chk.sv
// ----------------------------------------------------------------------------
// fsna_chk
// Port-level checks of the fixed-size node allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsna_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [fsna_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int SL = fsna_pkg::OUT_STAT_LSB;
    localparam int AW = fsna_pkg::ADDR_W;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One request in flight: no new request while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");

    // Drop the address on any failure
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[SL+1:SL] != fsna_pkg::ST_OK)
        |-> m_axis_tdata[AW-1:0] == '0)
        else $error("failed request carries an address");

    // Status only takes defined codes
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SL+1:SL] == fsna_pkg::ST_OK)
                       || (m_axis_tdata[SL+1:SL] == fsna_pkg::ST_NO_SLOT)
                       || (m_axis_tdata[SL+1:SL] == fsna_pkg::ST_BAD_FREE))
        else $error("undefined status code");

endmodule

bind fixed_size_node_allocator_top fsna_chk u_fsna_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
